// File: rtl/core/vac_pkg.sv
package vac_pkg;

    localparam int LANES = 4;

    typedef logic [3:0] fmt_t;

    localparam fmt_t FMT_NONE   = 4'd0;
    localparam fmt_t FMT_F32_1  = 4'd1;
    localparam fmt_t FMT_I16_1  = 4'd2;
    localparam fmt_t FMT_I8_1   = 4'd3;
    localparam fmt_t FMT_F32_2  = 4'd4;
    localparam fmt_t FMT_I16_2  = 4'd5;
    localparam fmt_t FMT_I8_2   = 4'd6;
    localparam fmt_t FMT_F32_3  = 4'd7;
    localparam fmt_t FMT_I16_3  = 4'd8;
    localparam fmt_t FMT_I8_3   = 4'd9;
    localparam fmt_t FMT_F32_4  = 4'd10;
    localparam fmt_t FMT_I16_4  = 4'd11;
    localparam fmt_t FMT_I8_4   = 4'd12;
    localparam fmt_t FMT_PACKED = 4'd13;

    typedef enum logic [1:0] {
        KIND_F32,
        KIND_I16,
        KIND_I8,
        KIND_PACKED
    } kind_t;

    typedef enum logic [2:0] {
        REG_SRC_FMT,
        REG_DST_FMT,
        REG_SB_EN,
        REG_SCALE_XY,
        REG_SCALE_ZW,
        REG_BIAS_XY,
        REG_BIAS_ZW,
        REG_UNUSED
    } cfg_idx_t;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // Per-stage advance enables for the arithmetic lanes.
    typedef struct packed {
        logic mul;
        logic norm;
        logic rnd;
        logic add;
        logic fin;
    } vac_lane_en_t;

    function automatic logic fmt_valid(fmt_t f);
        return f <= FMT_PACKED;
    endfunction

    function automatic kind_t fmt_kind(fmt_t f);
        kind_t k;
        case (f) inside
            FMT_F32_1, FMT_F32_2, FMT_F32_3, FMT_F32_4: k = KIND_F32;
            FMT_I16_1, FMT_I16_2, FMT_I16_3, FMT_I16_4: k = KIND_I16;
            FMT_I8_1, FMT_I8_2, FMT_I8_3, FMT_I8_4:     k = KIND_I8;
            default:                                    k = KIND_PACKED;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] fmt_dim(fmt_t f);
        logic [2:0] d;
        case (f) inside
            FMT_F32_1, FMT_I16_1, FMT_I8_1:             d = 3'd1;
            FMT_F32_2, FMT_I16_2, FMT_I8_2:             d = 3'd2;
            FMT_F32_3, FMT_I16_3, FMT_I8_3:             d = 3'd3;
            FMT_F32_4, FMT_I16_4, FMT_I8_4, FMT_PACKED: d = 3'd4;
            default:                                    d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] fmt_bytes(fmt_t f);
        logic [4:0] n;
        unique case (f)
            FMT_F32_1:  n = 5'd4;
            FMT_I16_1:  n = 5'd2;
            FMT_I8_1:   n = 5'd1;
            FMT_F32_2:  n = 5'd8;
            FMT_I16_2:  n = 5'd4;
            FMT_I8_2:   n = 5'd2;
            FMT_F32_3:  n = 5'd12;
            FMT_I16_3:  n = 5'd6;
            FMT_I8_3:   n = 5'd3;
            FMT_F32_4:  n = 5'd16;
            FMT_I16_4:  n = 5'd8;
            FMT_I8_4:   n = 5'd4;
            FMT_PACKED: n = 5'd2;
            default:    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/vac_fmul.sv
module vac_fmul
    import vac_pkg::*;
(
    input  logic         aclk,
    input  vac_lane_en_t en,
    input  logic [31:0]  a,
    input  logic [31:0]  b,
    output logic [31:0]  p
);

    function automatic logic [5:0] lzc48(logic [47:0] x);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (x[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // Stage 1: significand product.
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;

    logic               s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_zero_reg;
    logic signed [9:0]  s1_exp_reg;
    logic [47:0]        s1_prod_reg;

    always_comb begin
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        b_zero = (b[30:0] == '0);
        ma = {a[30:23] != '0, a[22:0]};
        mb = {b[30:23] != '0, b[22:0]};
        ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            s1_sign_reg <= a[31] ^ b[31];
            s1_nan_reg  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
            s1_inf_reg  <= a_inf | b_inf;
            s1_zero_reg <= a_zero | b_zero;
            s1_exp_reg  <= signed'({2'b00, ea}) + signed'({2'b00, eb}) - 10'sd127;
            s1_prod_reg <= ma * mb;
        end
    end

    // Stage 2: bring the leading one to the top bit.
    logic [5:0] lz;

    logic               s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_zero_reg;
    logic signed [9:0]  s2_exp_reg;
    logic [47:0]        s2_prod_reg;

    assign lz = lzc48(s1_prod_reg);

    always_ff @(posedge aclk) begin
        if (en.norm) begin
            s2_sign_reg <= s1_sign_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_exp_reg  <= s1_exp_reg + 10'sd1 - signed'({4'b0000, lz});
            s2_prod_reg <= s1_prod_reg << lz;
        end
    end

    // Stage 3: denormalize when below the normal range, then round to nearest even.
    logic signed [9:0] dshift;
    logic [4:0]        sh;
    logic [79:0]       wide;
    logic [47:0]       m48;
    logic              stk0, g, st, inc, tiny;
    logic [23:0]       mant;
    logic [7:0]        ebase;
    logic [30:0]       mag;
    logic [31:0]       p_next;
    logic [31:0]       p_reg;

    always_comb begin
        tiny   = s2_exp_reg < 10'sd1;
        dshift = 10'sd1 - s2_exp_reg;
        sh     = (dshift > 10'sd31) ? 5'd31 : dshift[4:0];
        wide   = {s2_prod_reg, 32'b0} >> sh;
        m48    = tiny ? wide[79:32] : s2_prod_reg;
        stk0   = tiny & (|wide[31:0]);
        mant   = m48[47:24];
        g      = m48[23];
        st     = (|m48[22:0]) | stk0;
        inc    = g & (st | mant[0]);
        ebase  = tiny ? 8'd0 : s2_exp_reg[7:0];
        mag    = {ebase, mant[22:0]} + {30'b0, inc};
        if (s2_nan_reg) begin
            p_next = QNAN;
        end else if (s2_inf_reg || (s2_exp_reg > 10'sd254)) begin
            p_next = {s2_sign_reg, 8'hFF, 23'b0};
        end else if (s2_zero_reg) begin
            p_next = {s2_sign_reg, 31'b0};
        end else begin
            p_next = {s2_sign_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.rnd) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/core/vac_fadd.sv
module vac_fadd
    import vac_pkg::*;
(
    input  logic         aclk,
    input  vac_lane_en_t en,
    input  logic [31:0]  x,
    input  logic [31:0]  y,
    output logic [31:0]  s
);

    function automatic logic [4:0] lzc28(logic [27:0] v);
        logic [4:0] n;
        n = 5'd28;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    // Stage 1: order by magnitude, align the smaller operand, add or subtract.
    logic        x_nan, x_inf, y_nan, y_inf, swap, sub;
    logic [31:0] op_a, op_b;
    logic [7:0]  ea, eb, ediff;
    logic [4:0]  dcl;
    logic [26:0] ma, mb;
    logic [58:0] bw;
    logic [26:0] bal;

    logic        s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_inf_sign_reg, s1_zsign_reg;
    logic [7:0]  s1_exp_reg;
    logic [27:0] s1_sum_reg;

    always_comb begin
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != '0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == '0);
        swap  = y[30:0] > x[30:0];
        op_a  = swap ? y : x;
        op_b  = swap ? x : y;
        ea    = (op_a[30:23] == '0) ? 8'd1 : op_a[30:23];
        eb    = (op_b[30:23] == '0) ? 8'd1 : op_b[30:23];
        ediff = ea - eb;
        dcl   = (ediff > 8'd31) ? 5'd31 : ediff[4:0];
        ma    = {op_a[30:23] != '0, op_a[22:0], 3'b000};
        mb    = {op_b[30:23] != '0, op_b[22:0], 3'b000};
        bw    = {mb, 32'b0} >> dcl;
        bal   = bw[58:32] | {26'b0, |bw[31:0]};
        sub   = op_a[31] ^ op_b[31];
    end

    always_ff @(posedge aclk) begin
        if (en.add) begin
            s1_sign_reg     <= op_a[31];
            s1_nan_reg      <= x_nan | y_nan | (x_inf & y_inf & (x[31] ^ y[31]));
            s1_inf_reg      <= x_inf | y_inf;
            s1_inf_sign_reg <= x_inf ? x[31] : y[31];
            s1_zsign_reg    <= x[31] & y[31];
            s1_exp_reg      <= ea;
            s1_sum_reg      <= sub ? ({1'b0, ma} - {1'b0, bal}) : ({1'b0, ma} + {1'b0, bal});
        end
    end

    // Stage 2: normalize (never below the minimum exponent) and round to nearest even.
    logic [4:0]  lz, lzm1, sl;
    logic [7:0]  em1;
    logic [27:0] sn;
    logic [8:0]  e9, ebase;
    logic [23:0] mant;
    logic        g, st, inc;
    logic [30:0] mag;
    logic [31:0] s_next;
    logic [31:0] s_reg;

    always_comb begin
        lz   = lzc28(s1_sum_reg);
        lzm1 = lz - 5'd1;
        em1  = s1_exp_reg - 8'd1;
        sl   = ({3'b000, lzm1} < em1) ? lzm1 : em1[4:0];
        sn   = s1_sum_reg << sl;
        if (s1_sum_reg[27]) begin
            mant  = s1_sum_reg[27:4];
            g     = s1_sum_reg[3];
            st    = |s1_sum_reg[2:0];
            e9    = {1'b0, s1_exp_reg} + 9'd1;
            ebase = e9;
        end else begin
            mant  = sn[26:3];
            g     = sn[2];
            st    = |sn[1:0];
            e9    = {1'b0, s1_exp_reg} - {4'b0000, sl};
            ebase = sn[26] ? e9 : 9'd0;
        end
        inc = g & (st | mant[0]);
        mag = {ebase[7:0], mant[22:0]} + {30'b0, inc};
        if (s1_nan_reg) begin
            s_next = QNAN;
        end else if (s1_inf_reg) begin
            s_next = {s1_inf_sign_reg, 8'hFF, 23'b0};
        end else if (s1_sum_reg == '0) begin
            s_next = {s1_zsign_reg, 31'b0};
        end else if (ebase > 9'd254) begin
            s_next = {s1_sign_reg, 8'hFF, 23'b0};
        end else begin
            s_next = {s1_sign_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.fin) begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule

// File: rtl/core/vac_lane.sv
module vac_lane
    import vac_pkg::*;
(
    input  logic         aclk,
    input  vac_lane_en_t en,
    input  logic         sb_en,
    input  logic [31:0]  comp,
    input  logic [31:0]  scale,
    input  logic [31:0]  bias,
    output logic [31:0]  result
);

    logic [31:0] prod;
    logic [31:0] sum;
    logic [31:0] raw2_reg, raw3_reg, raw4_reg, raw5_reg, raw6_reg;

    vac_fmul u_fmul (
        .aclk (aclk),
        .en   (en),
        .a    (comp),
        .b    (scale),
        .p    (prod)
    );

    vac_fadd u_fadd (
        .aclk (aclk),
        .en   (en),
        .x    (prod),
        .y    (bias),
        .s    (sum)
    );

    // The unscaled component travels beside the arithmetic so its bits stay exact.
    always_ff @(posedge aclk) begin
        if (en.mul)  raw2_reg <= comp;
        if (en.norm) raw3_reg <= raw2_reg;
        if (en.rnd)  raw4_reg <= raw3_reg;
        if (en.add)  raw5_reg <= raw4_reg;
        if (en.fin)  raw6_reg <= raw5_reg;
    end

    assign result = sb_en ? sum : raw6_reg;

endmodule

// File: rtl/core/vac_merge.sv
module vac_merge
    import vac_pkg::*;
(
    input  fmt_t        src_fmt,
    input  fmt_t        dst_fmt,
    input  logic        sb_en,
    input  logic [31:0] lane_val [LANES],
    output logic [63:0] dst_low,
    output logic [63:0] dst_high,
    output logic [4:0]  dst_bytes,
    output logic        format_error
);

    // Truncate toward zero and keep the low 16 bits; NaN and infinity give zero.
    function automatic logic [15:0] trunc16(logic [31:0] v);
        logic [7:0]  e;
        logic [23:0] m;
        logic [7:0]  sh;
        logic [39:0] up;
        logic [23:0] dn;
        logic [15:0] mag;
        e = v[30:23];
        m = {1'b1, v[22:0]};
        sh = 8'd0;
        up = '0;
        dn = '0;
        if ((e == 8'hFF) || (e < 8'd127)) begin
            mag = '0;
        end else if (e >= 8'd150) begin
            sh = e - 8'd150;
            up = {16'b0, m} << sh[3:0];
            mag = (sh >= 8'd16) ? 16'd0 : up[15:0];
        end else begin
            sh = 8'd150 - e;
            dn = m >> sh[4:0];
            mag = dn[15:0];
        end
        return v[31] ? (16'd0 - mag) : mag;
    endfunction

    logic [127:0] d;
    logic [127:0] raw;
    logic [15:0]  t [LANES];
    logic         w_nz;
    logic [2:0]   dd;
    logic [4:0]   n;
    logic         bad;

    always_comb begin
        d    = '0;
        raw  = '0;
        n    = fmt_bytes(dst_fmt);
        dd   = fmt_dim(dst_fmt);
        bad  = !fmt_valid(src_fmt) || !fmt_valid(dst_fmt) || (dst_fmt == FMT_NONE);
        w_nz = (lane_val[3][30:23] >= 8'd127) && (lane_val[3][30:23] != 8'hFF);
        for (int i = 0; i < LANES; i++) begin
            t[i] = trunc16(lane_val[i]);
            raw[32*i +: 32] = lane_val[i];
        end
        if (!sb_en && (src_fmt == dst_fmt)) begin
            d = raw;
        end else begin
            case (fmt_kind(dst_fmt))
                KIND_F32: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < dd) d[32*i +: 32] = lane_val[i];
                    end
                end
                KIND_I16: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < dd) d[16*i +: 16] = t[i];
                    end
                end
                KIND_I8: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < dd) d[8*i +: 8] = t[i][7:0];
                    end
                end
                default: begin
                    d[15:0] = {w_nz, t[2][4:0], t[1][4:0], t[0][4:0]};
                end
            endcase
        end
        // Bytes beyond the destination size are cleared.
        for (int j = 0; j < 16; j++) begin
            if (5'(j) >= n) d[8*j +: 8] = 8'h00;
        end
        if (bad) begin
            d = '0;
        end
    end

    assign dst_low      = d[63:0];
    assign dst_high     = d[127:64];
    assign dst_bytes    = bad ? 5'd0 : n;
    assign format_error = bad;

endmodule

// File: rtl/core/vertex_attribute_converter.sv
// Throughput: one item per cycle; four component lanes of multiply then add
// run side by side, and the seven-stage pipeline advances stage by stage, so
// empty stages absorb a stalled output before the input side stalls.
// Reset (aresetn low, synchronous) empties the pipeline and sets the format
// registers to none, scale and bias off, scales to 1.0 and biases to 0.0.
module vertex_attribute_converter
    import vac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_src_low,
    input  logic [63:0] s_src_high,
    input  logic        s_in_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_dst_low,
    output logic [63:0] m_dst_high,
    output logic [4:0]  m_dst_bytes,
    output logic        m_format_error,
    output logic        m_out_last
);

    localparam int PIPE_DEPTH = 7;

    // Signed 16-bit integer to single precision; always exact.
    function automatic logic [31:0] i16_to_f32(logic [15:0] x);
        logic [15:0] mag;
        logic [15:0] nrm;
        logic [4:0]  lz;
        mag = x[15] ? (16'd0 - x) : x;
        lz = 5'd16;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) lz = 5'(15 - i);
        end
        nrm = mag << lz[3:0];
        if (mag == '0) begin
            return 32'd0;
        end
        return {x[15], 8'd142 - {3'b000, lz}, nrm[14:0], 8'b0};
    endfunction

    // Configuration registers.
    fmt_t        src_fmt_reg, dst_fmt_reg;
    logic        sb_en_reg;
    logic [63:0] scale_xy_reg, scale_zw_reg, bias_xy_reg, bias_zw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg  <= FMT_NONE;
            dst_fmt_reg  <= FMT_NONE;
            sb_en_reg    <= 1'b0;
            scale_xy_reg <= 64'h3F80_0000_3F80_0000;
            scale_zw_reg <= 64'h3F80_0000_3F80_0000;
            bias_xy_reg  <= '0;
            bias_zw_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SRC_FMT:  src_fmt_reg  <= cfg_data[3:0];
                REG_DST_FMT:  dst_fmt_reg  <= cfg_data[3:0];
                REG_SB_EN:    sb_en_reg    <= cfg_data[0];
                REG_SCALE_XY: scale_xy_reg <= cfg_data;
                REG_SCALE_ZW: scale_zw_reg <= cfg_data;
                REG_BIAS_XY:  bias_xy_reg  <= cfg_data;
                REG_BIAS_ZW:  bias_zw_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage takes new contents when empty or when the next one moves.
    logic [PIPE_DEPTH:1] vld_reg, vld_next, adv;
    logic [PIPE_DEPTH:1] last_reg;

    always_comb begin
        adv[PIPE_DEPTH] = !vld_reg[PIPE_DEPTH] || m_ready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
        vld_next[1] = adv[1] ? s_valid : vld_reg[1];
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) last_reg[1] <= s_in_last;
        for (int k = 2; k <= PIPE_DEPTH; k++) begin
            if (adv[k]) last_reg[k] <= last_reg[k - 1];
        end
    end

    assign s_ready = adv[1];

    // Stage 1: decode the source into four single-precision components, or copy it raw.
    logic [127:0] src;
    logic [31:0]  comp_next [LANES];
    logic [31:0]  comp_reg  [LANES];
    logic [2:0]   sd;
    logic [15:0]  pk;

    always_comb begin
        src = {s_src_high, s_src_low};
        sd  = fmt_dim(src_fmt_reg);
        pk  = src[15:0];
        for (int i = 0; i < LANES; i++) begin
            comp_next[i] = '0;
        end
        if (!sb_en_reg && (src_fmt_reg == dst_fmt_reg)) begin
            // Straight copy: raw bytes ride the lanes untouched.
            for (int i = 0; i < LANES; i++) begin
                comp_next[i] = src[32*i +: 32];
            end
        end else if ((src_fmt_reg != FMT_NONE) && fmt_valid(src_fmt_reg)) begin
            case (fmt_kind(src_fmt_reg))
                KIND_F32: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < sd) comp_next[i] = src[32*i +: 32];
                    end
                end
                KIND_I16: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < sd) comp_next[i] = i16_to_f32(src[16*i +: 16]);
                    end
                end
                KIND_I8: begin
                    for (int i = 0; i < LANES; i++) begin
                        if (3'(i) < sd) begin
                            comp_next[i] = i16_to_f32({{8{src[8*i+7]}}, src[8*i +: 8]});
                        end
                    end
                end
                default: begin
                    comp_next[0] = i16_to_f32({11'b0, pk[4:0]});
                    comp_next[1] = i16_to_f32({11'b0, pk[9:5]});
                    comp_next[2] = i16_to_f32({11'b0, pk[14:10]});
                    comp_next[3] = i16_to_f32({15'b0, pk[15]});
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < LANES; i++) begin
                comp_reg[i] <= comp_next[i];
            end
        end
    end

    // Stages 2 to 6: one scale-and-bias lane per component.
    vac_lane_en_t lane_en;
    logic [31:0]  lane_scale [LANES];
    logic [31:0]  lane_bias  [LANES];
    logic [31:0]  lane_val   [LANES];

    assign lane_en.mul  = adv[2];
    assign lane_en.norm = adv[3];
    assign lane_en.rnd  = adv[4];
    assign lane_en.add  = adv[5];
    assign lane_en.fin  = adv[6];

    assign lane_scale[0] = scale_xy_reg[31:0];
    assign lane_scale[1] = scale_xy_reg[63:32];
    assign lane_scale[2] = scale_zw_reg[31:0];
    assign lane_scale[3] = scale_zw_reg[63:32];
    assign lane_bias[0]  = bias_xy_reg[31:0];
    assign lane_bias[1]  = bias_xy_reg[63:32];
    assign lane_bias[2]  = bias_zw_reg[31:0];
    assign lane_bias[3]  = bias_zw_reg[63:32];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vac_lane u_lane (
            .aclk   (aclk),
            .en     (lane_en),
            .sb_en  (sb_en_reg),
            .comp   (comp_reg[g]),
            .scale  (lane_scale[g]),
            .bias   (lane_bias[g]),
            .result (lane_val[g])
        );
    end

    // Stage 7: encode into the destination format and hold for the consumer.
    logic [63:0] enc_low, enc_high;
    logic [4:0]  enc_bytes;
    logic        enc_err;

    vac_merge u_merge (
        .src_fmt      (src_fmt_reg),
        .dst_fmt      (dst_fmt_reg),
        .sb_en        (sb_en_reg),
        .lane_val     (lane_val),
        .dst_low      (enc_low),
        .dst_high     (enc_high),
        .dst_bytes    (enc_bytes),
        .format_error (enc_err)
    );

    logic [63:0] dst_low_reg, dst_high_reg;
    logic [4:0]  dst_bytes_reg;
    logic        format_error_reg;

    always_ff @(posedge aclk) begin
        if (adv[PIPE_DEPTH]) begin
            dst_low_reg      <= enc_low;
            dst_high_reg     <= enc_high;
            dst_bytes_reg    <= enc_bytes;
            format_error_reg <= enc_err;
        end
    end

    assign m_valid        = vld_reg[PIPE_DEPTH];
    assign m_dst_low      = dst_low_reg;
    assign m_dst_high     = dst_high_reg;
    assign m_dst_bytes    = dst_bytes_reg;
    assign m_format_error = format_error_reg;
    assign m_out_last     = last_reg[PIPE_DEPTH];

endmodule
